FILE: rtl/dqd_pkg.sv
// ---------------------------------------------------------------------------
// dqd_pkg
// Shared types and codes for the two-queue dispatcher with work stealing.
// ---------------------------------------------------------------------------
package dqd_pkg;

   localparam int KIND_W   = 2;
   localparam int SIZE_W   = 32;
   localparam int ENTRY_W  = KIND_W + SIZE_W;
   localparam int POLICY_W = 3;
   localparam int OP_W     = 2;

   // Request operation codes
   localparam logic [OP_W-1:0] OP_ADD         = 2'd0;
   localparam logic [OP_W-1:0] OP_TAKE_FIRST  = 2'd1;
   localparam logic [OP_W-1:0] OP_TAKE_SECOND = 2'd2;

   // Dispatch policy codes; codes 5 to 7 are unused
   localparam logic [POLICY_W-1:0] POL_FIRST     = 3'd0;
   localparam logic [POLICY_W-1:0] POL_SECOND    = 3'd1;
   localparam logic [POLICY_W-1:0] POL_ALTERNATE = 3'd2;
   localparam logic [POLICY_W-1:0] POL_SIZE      = 3'd3;
   localparam logic [POLICY_W-1:0] POL_STEAL     = 3'd4;

   // Configuration register indexes
   localparam logic CSR_POLICY    = 1'b0;
   localparam logic CSR_THRESHOLD = 1'b1;

   // Outcome of one request, handed from the scheduler to the output stage
   typedef struct packed {
      logic accepted;
      logic unit;
      logic stolen;
      logic deliver;   // a queue entry was read for this transaction
      logic src;       // queue that was read: 0 first, 1 second
   } disp_type;

endpackage

FILE: rtl/dqd_mem.sv
// ---------------------------------------------------------------------------
// dqd_mem
// Task queue storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module dqd_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 34,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/dqd_sched.sv
// ---------------------------------------------------------------------------
// dqd_sched
// Queue pointers, policy decision and memory port control.
// ---------------------------------------------------------------------------
module dqd_sched #(
   parameter int QUEUE_DEPTH = 16,
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [dqd_pkg::OP_W-1:0]      op,
   input  logic [dqd_pkg::SIZE_W-1:0]    task_size,
   input  logic [dqd_pkg::POLICY_W-1:0]  policy,
   input  logic [dqd_pkg::SIZE_W-1:0]    threshold,
   output logic [1:0]                    wr_en,
   output logic [PTR_W-1:0]              wr_addr,
   output logic [1:0]                    rd_en,
   output logic [PTR_W-1:0]              rd_addr,
   output dqd_pkg::disp_type             disp
);

   logic [PTR_W-1:0] head0_ff, head0_in, head1_ff, head1_in;
   logic [PTR_W-1:0] tail0_ff, tail0_in, tail1_ff, tail1_in;
   logic [CNT_W-1:0] cnt0_ff, cnt0_in, cnt1_ff, cnt1_in;
   logic             turn_ff, turn_in;

   logic full0, full1, empty0, empty1;
   logic tgt, pol_ok, tgt_full, me, own_empty, oth_empty, flip;
   logic [1:0] wr_req, rd_req;

   assign full0  = (cnt0_ff == CNT_W'(QUEUE_DEPTH));
   assign full1  = (cnt1_ff == CNT_W'(QUEUE_DEPTH));
   assign empty0 = (cnt0_ff == '0);
   assign empty1 = (cnt1_ff == '0);

   always_comb begin
      disp      = '0;
      wr_req    = '0;
      rd_req    = '0;
      wr_addr   = '0;
      rd_addr   = '0;
      tgt       = 1'b0;
      pol_ok    = 1'b0;
      flip      = 1'b0;
      tgt_full  = 1'b0;
      me        = 1'b0;
      own_empty = 1'b1;
      oth_empty = 1'b1;
      case (op)
         dqd_pkg::OP_ADD: begin
            pol_ok = 1'b1;
            case (policy)
               dqd_pkg::POL_FIRST:                      tgt = 1'b0;
               dqd_pkg::POL_SECOND, dqd_pkg::POL_STEAL: tgt = 1'b1;
               dqd_pkg::POL_ALTERNATE: begin
                  tgt  = ~turn_ff;
                  flip = 1'b1;
               end
               dqd_pkg::POL_SIZE:                       tgt = ~(task_size < threshold);
               default:                                 pol_ok = 1'b0;
            endcase
            if (pol_ok) begin
               disp.unit = tgt;
               tgt_full  = tgt ? full1 : full0;
               if (!tgt_full) begin
                  disp.accepted = 1'b1;
                  wr_req[tgt]   = 1'b1;
                  wr_addr       = tgt ? tail1_ff : tail0_ff;
               end
            end
         end
         dqd_pkg::OP_TAKE_FIRST, dqd_pkg::OP_TAKE_SECOND: begin
            me        = (op == dqd_pkg::OP_TAKE_SECOND);
            disp.unit = me;
            own_empty = me ? empty1 : empty0;
            oth_empty = me ? empty0 : empty1;
            if (!own_empty) begin
               disp.accepted = 1'b1;
               disp.deliver  = 1'b1;
               disp.src      = me;
            end else if (policy == dqd_pkg::POL_STEAL && !oth_empty) begin
               disp.accepted = 1'b1;
               disp.deliver  = 1'b1;
               disp.stolen   = 1'b1;
               disp.src      = ~me;
            end
            if (disp.deliver) begin
               rd_req[disp.src] = 1'b1;
               rd_addr          = disp.src ? head1_ff : head0_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign wr_en = go ? wr_req : 2'b00;
   assign rd_en = go ? rd_req : 2'b00;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      head0_in = head0_ff;
      head1_in = head1_ff;
      tail0_in = tail0_ff;
      tail1_in = tail1_ff;
      cnt0_in  = cnt0_ff;
      cnt1_in  = cnt1_ff;
      turn_in  = turn_ff;
      if (go && flip) begin
         turn_in = ~turn_ff;
      end
      if (wr_en[0]) begin
         tail0_in = (tail0_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail0_ff + 1'b1;
         cnt0_in  = cnt0_ff + 1'b1;
      end
      if (wr_en[1]) begin
         tail1_in = (tail1_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail1_ff + 1'b1;
         cnt1_in  = cnt1_ff + 1'b1;
      end
      if (rd_en[0]) begin
         head0_in = (head0_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head0_ff + 1'b1;
         cnt0_in  = cnt0_ff - 1'b1;
      end
      if (rd_en[1]) begin
         head1_in = (head1_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head1_ff + 1'b1;
         cnt1_in  = cnt1_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head0_ff <= '0;
         head1_ff <= '0;
         tail0_ff <= '0;
         tail1_ff <= '0;
         cnt0_ff  <= '0;
         cnt1_ff  <= '0;
         turn_ff  <= 1'b1;
      end else begin
         head0_ff <= head0_in;
         head1_ff <= head1_in;
         tail0_ff <= tail0_in;
         tail1_ff <= tail1_in;
         cnt0_ff  <= cnt0_in;
         cnt1_ff  <= cnt1_in;
         turn_ff  <= turn_in;
      end
   end

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      !((wr_en[0] && full0) || (wr_en[1] && full1)))
      else $error("write issued to a full queue");

   a_no_read_empty: assert property (@(posedge clock) disable iff (reset)
      !((rd_en[0] && empty0) || (rd_en[1] && empty1)))
      else $error("read issued to an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt0_ff <= CNT_W'(QUEUE_DEPTH) && cnt1_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_add_counts: assert property (@(posedge clock) disable iff (reset)
      wr_en[0] |=> cnt0_ff == $past(cnt0_ff) + 1'b1)
      else $error("first queue count did not advance on write");

endmodule

FILE: rtl/dual_queue_dispatch_with_stealing.sv
// ---------------------------------------------------------------------------
// dual_queue_dispatch_with_stealing
// Two task queues, one per execution unit, with policy dispatch and stealing.
// ---------------------------------------------------------------------------
// Usage:
//   req_ carries one request per transaction: add a task, or a take by the
//   first or second unit. rsp_ returns exactly one result per request, in
//   order. csr_ writes policy_mode (index 0) and size_threshold (index 1);
//   write it only while no request is in flight.
// Pipeline and throughput:
//   In the accepting cycle the scheduler decides, and at the accepting edge
//   it moves the queue pointers and issues the memory access. The request
//   then waits in the pending stage while the queue memory returns its
//   registered read data; from there it moves into the output register
//   that drives rsp_tvalid. With rsp_tready high the block takes one
//   request every cycle; pointer state updates at acceptance so back-to-back
//   requests see each other.
// Reset:
//   Clears both queues (pointers and counts), sets the alternate turn to
//   the first unit, and sets policy_mode and size_threshold to zero. The
//   queue memories themselves are not cleared; empty entries are never read.
// Stall:
//   A stalled rsp_ holds its result; the pending stage holds one more, and
//   req_tready drops only when both are occupied and rsp_tready is low.
// ---------------------------------------------------------------------------
module dual_queue_dispatch_with_stealing #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [1:0] operation, [3:2] task_kind,
                                    // [35:4] task_size, [39:36] zero
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [0] accepted, [1] unit, [2] stolen,
                                    // [4:3] out_task_kind,
                                    // [36:5] out_task_size, [39:37] zero
   // Configuration write port
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // Configuration registers
   logic [dqd_pkg::POLICY_W-1:0] policy_ff;
   logic [dqd_pkg::SIZE_W-1:0]   threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= '0;
         threshold_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            dqd_pkg::CSR_POLICY:    policy_ff    <= csr_wdata[dqd_pkg::POLICY_W-1:0];
            dqd_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Unpack the request
   logic [dqd_pkg::OP_W-1:0]   req_op;
   logic [dqd_pkg::KIND_W-1:0] req_kind;
   logic [dqd_pkg::SIZE_W-1:0] req_size;

   assign req_op   = req_tdata[1:0];
   assign req_kind = req_tdata[3:2];
   assign req_size = req_tdata[35:4];

   // Pipeline handshake: the pending stage drains into the output register
   logic pend_valid_ff, rsp_valid_ff, out_free, go;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !pend_valid_ff || out_free;
   assign go         = req_tvalid && req_tready;

   // Scheduler and queue memories
   logic [1:0]                  wr_en, rd_en;
   logic [PTR_W-1:0]            wr_addr, rd_addr;
   logic [dqd_pkg::ENTRY_W-1:0] wr_word, rd_word0, rd_word1;
   dqd_pkg::disp_type           disp;

   assign wr_word = {req_kind, req_size};

   dqd_sched #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_sched (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .op        (req_op),
      .task_size (req_size),
      .policy    (policy_ff),
      .threshold (threshold_ff),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .disp      (disp)
   );

   dqd_mem #(.DEPTH(QUEUE_DEPTH), .WIDTH(dqd_pkg::ENTRY_W)) u_first_queue (
      .clock   (clock),
      .wr_en   (wr_en[0]),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (rd_en[0]),
      .rd_addr (rd_addr),
      .rd_data (rd_word0)
   );

   dqd_mem #(.DEPTH(QUEUE_DEPTH), .WIDTH(dqd_pkg::ENTRY_W)) u_second_queue (
      .clock   (clock),
      .wr_en   (wr_en[1]),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (rd_en[1]),
      .rd_addr (rd_addr),
      .rd_data (rd_word1)
   );

   // Pending stage: hold the decision while the memory read completes
   dqd_pkg::disp_type pend_disp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (go) begin
         pend_valid_ff <= 1'b1;
      end else if (out_free) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         pend_disp_ff <= disp;
      end
   end

   // Output register: pick the read data of the source queue, zero if none
   logic [dqd_pkg::ENTRY_W-1:0] pend_word;
   logic [36:0]                 rsp_data_ff, rsp_data_in;

   assign pend_word   = !pend_disp_ff.deliver ? '0 :
                        (pend_disp_ff.src ? rd_word1 : rd_word0);
   assign rsp_data_in = {pend_word[dqd_pkg::SIZE_W-1:0],
                         pend_word[dqd_pkg::ENTRY_W-1:dqd_pkg::SIZE_W],
                         pend_disp_ff.stolen, pend_disp_ff.unit,
                         pend_disp_ff.accepted};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pend_valid_ff && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_valid_ff && out_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

endmodule
